### rtl/dzbr_pkg.sv
// ----------------------------------------------------------------------------
// dzbr_pkg
// Shared constants, types and helper functions of the delta/zigzag bit-pack
// encoder with zero-block run-length coding.
// ----------------------------------------------------------------------------
package dzbr_pkg;

	localparam int MAX_DIMS      = 8;
	localparam int BLOCK_ROWS    = 8;
	localparam int GROUP_BLOCKS  = 2;
	localparam int MAX_RUN       = 32767;
	localparam int MIN_CODED_LEN = 8 * BLOCK_ROWS * GROUP_BLOCKS;
	localparam int BLK_DEPTH     = BLOCK_ROWS * MAX_DIMS;
	localparam int GRP_DEPTH     = GROUP_BLOCKS * BLK_DEPTH + 16;
	localparam int HDR_BITS      = 3 * MAX_DIMS * GROUP_BLOCKS;

	localparam int SAMPLE_W = 8;
	localparam int LEN_W    = 32;
	localparam int DIMS_W   = 4;
	localparam int RUN_W    = 15;
	localparam int OUT_W    = 64;
	localparam int CNT_W    = 4;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 72;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_REC_LO,
		S_REC_HI,
		S_PAD,
		S_HDR,
		S_R_RD,
		S_R_ACC,
		S_R_FL,
		S_R_END,
		S_E_RD,
		S_E_PUSH,
		S_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		RET_DEC,
		RET_FLUSH,
		RET_TAIL
	} ret_t;

	typedef struct packed {
		logic accept;
		logic run_inc;
		logic rec_lo;
		logic rec_hi;
		logic rec_done;
		logic pad_wr;
		logic hdr_wr;
		logic row_acc;
		logic row_fl;
		logic slot_inc;
		logic emit_push;
		logic emit_done;
		logic set_tail;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic tail_now;
		logic block_end;
		logic rowzero;
		logic run_full;
		logic run_nz;
		logic run_big;
		logic left_gt;
		logic slot;
		logic row_end;
		logic rem_nz;
		logic blk_last;
		logic bf_zero;
		logic push_ok;
		logic flush_ok;
		logic emit_last;
	} sts_t;

	function automatic logic [3:0] bit_width(input logic [7:0] v);
		logic [3:0] w;
		w = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) w = 4'(i + 1);
		end
		if (w == 4'd7) w = 4'd8;
		return w;
	endfunction

	function automatic logic [2:0] hdr_code(input logic [3:0] w);
		return (w == 4'd8) ? 3'd7 : w[2:0];
	endfunction

endpackage

### rtl/dzbr_ram.sv
// ----------------------------------------------------------------------------
// dzbr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dzbr_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/dzbr_ctrl.sv
// ----------------------------------------------------------------------------
// dzbr_ctrl
// Sequencer: accepts samples, steps block coding, run records, group
// emission and the final flush of each beat burst.
// ----------------------------------------------------------------------------
module dzbr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  dzbr_pkg::sts_t sts,
	output dzbr_pkg::cmd_t cmd
);
	import dzbr_pkg::*;

	state_t state_q, state_d;
	logic   pad_q, pad_d;
	ret_t   ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pad_q   <= 1'b0;
			ret_q   <= RET_FLUSH;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pad_d    = pad_q;
		ret_d    = ret_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.tail_now) state_d = S_FLUSH;
					else if (sts.block_end) state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.rowzero && !sts.run_full) begin
					cmd.run_inc = 1'b1;
					if (sts.left_gt) begin
						state_d = S_FLUSH;
					end else begin
						pad_d   = 1'b1;
						state_d = S_REC_LO;
					end
				end else if (sts.run_nz) begin
					pad_d   = 1'b0;
					state_d = S_REC_LO;
				end else begin
					state_d = S_HDR;
				end
			end
			S_REC_LO, S_REC_HI: begin
				if (state_q == S_REC_LO) cmd.rec_lo = 1'b1;
				else cmd.rec_hi = 1'b1;
				if (state_q == S_REC_LO && sts.run_big) begin
					state_d = S_REC_HI;
				end else begin
					cmd.rec_done = 1'b1;
					if (pad_q) begin
						ret_d   = RET_TAIL;
						state_d = sts.slot ? S_E_RD : S_PAD;
					end else if (sts.slot) begin
						ret_d   = RET_DEC;
						state_d = S_E_RD;
					end else begin
						state_d = sts.rowzero ? S_DEC : S_HDR;
					end
				end
			end
			S_PAD: begin
				cmd.pad_wr = 1'b1;
				state_d    = S_E_RD;
			end
			S_HDR: begin
				cmd.hdr_wr = 1'b1;
				state_d    = S_R_RD;
			end
			S_R_RD: state_d = S_R_ACC;
			S_R_ACC: begin
				cmd.row_acc = 1'b1;
				if (sts.row_end && sts.rem_nz) state_d = S_R_FL;
				else if (sts.blk_last) state_d = S_R_END;
				else state_d = S_R_RD;
			end
			S_R_FL: begin
				cmd.row_fl = 1'b1;
				state_d    = sts.bf_zero ? S_R_END : S_R_RD;
			end
			S_R_END: begin
				cmd.slot_inc = 1'b1;
				if (sts.slot) begin
					ret_d   = RET_FLUSH;
					state_d = S_E_RD;
				end else begin
					state_d = S_FLUSH;
				end
			end
			S_E_RD: state_d = S_E_PUSH;
			S_E_PUSH: begin
				if (sts.push_ok) begin
					cmd.emit_push = 1'b1;
					if (sts.emit_last) begin
						cmd.emit_done = 1'b1;
						cmd.set_tail  = (ret_q == RET_TAIL);
						state_d       = (ret_q == RET_DEC) ? S_DEC : S_FLUSH;
					end else begin
						state_d = S_E_RD;
					end
				end
			end
			S_FLUSH: begin
				if (sts.flush_ok) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

### rtl/dzbr_dp.sv
// ----------------------------------------------------------------------------
// dzbr_dp
// Datapath: config registers, delta/zigzag front end, block and group RAMs,
// header bits, row packer, run counter, byte packer and output register.
// ----------------------------------------------------------------------------
module dzbr_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [dzbr_pkg::LEN_W-1:0]     cfg_data,
	input  logic [dzbr_pkg::SAMPLE_W-1:0]  sample,
	input  dzbr_pkg::cmd_t                 cmd,
	output dzbr_pkg::sts_t                 sts,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [dzbr_pkg::OUT_W-1:0]     out_bytes,
	output logic [dzbr_pkg::CNT_W-1:0]     byte_count,
	output logic                           burst_end
);
	import dzbr_pkg::*;

	localparam int BA_W = $clog2(BLK_DEPTH);
	localparam int GA_W = $clog2(GRP_DEPTH);

	logic [DIMS_W-1:0]   dims_q;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    pos_q;
	logic                tail_q;
	logic [7:0]          prev_q [MAX_DIMS];
	logic [7:0]          orv_q [MAX_DIMS];
	logic [BA_W-1:0]     bf_q;
	logic [2:0]          d_q;
	logic [RUN_W-1:0]    run_q;
	logic                slot_q;
	logic [HDR_BITS-1:0] header_q;
	logic [GA_W-1:0]     gf_q;
	logic [GA_W-1:0]     e_q;
	logic [14:0]         acc_q;
	logic [2:0]          nacc_q;
	logic [63:0]         pk_q;
	logic [CNT_W-1:0]    pkc_q;

	logic [3:0]  nd;
	logic [2:0]  nd_m1;
	logic [BA_W-1:0] bf_last;
	logic [7:0]  gs;
	logic [5:0]  hsum;
	logic [2:0]  hb;
	logic [4:0]  sh3;
	logic [LEN_W-1:0] left;
	logic        start;
	logic [7:0]  dv;
	logic [7:0]  zz;
	logic [3:0]  w [MAX_DIMS];
	logic [23:0] codes;
	logic        rowzero;
	logic [7:0]  brd;
	logic [7:0]  grd;
	logic        gwe;
	logic [7:0]  gwd;
	logic [14:0] acc_new;
	logic [3:0]  nsum;
	logic [3:0]  wd;
	logic [GA_W-1:0] total;
	logic [GA_W-1:0] graddr;
	logic [63:0] hdr64;
	logic [7:0]  hsel;
	logic [7:0]  ebyte;
	logic        ofree;
	logic        adv;
	logic [63:0] pk_ins;

	assign nd      = (dims_q == 4'd0) ? 4'd1 :
	                 (dims_q > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : dims_q;
	assign nd_m1   = 3'(nd - 4'd1);
	assign bf_last = BA_W'({nd, 3'b000} - 7'd1);
	assign gs      = {nd, 4'b0000};
	assign hsum    = 6'({nd, 2'b00} + {1'b0, nd, 1'b0});
	assign hb      = 3'((hsum + 6'd7) >> 3);
	assign sh3     = 5'({nd, 1'b0} + {1'b0, nd});
	assign left    = (len_q > pos_q) ? (len_q - pos_q) : '0;
	assign start   = !slot_q && (run_q == '0) && (bf_q == '0);

	assign dv = sample - prev_q[d_q];
	assign zz = {dv[6:0], 1'b0} ^ {8{dv[7]}};

	always_comb begin
		rowzero = 1'b1;
		for (int i = 0; i < MAX_DIMS; i++) begin
			w[i]            = bit_width(orv_q[i]);
			codes[3*i +: 3] = hdr_code(w[i]);
			if (orv_q[i] != 8'd0) rowzero = 1'b0;
		end
	end

	// row packer
	assign wd      = w[d_q];
	assign acc_new = acc_q | (15'(brd) << nacc_q);
	assign nsum    = 4'(nacc_q) + wd;

	// group emission
	assign total  = GA_W'(hb) + gf_q;
	assign graddr = e_q - GA_W'(hb);
	assign hdr64  = {16'd0, header_q};
	assign hsel   = hdr64[{e_q[2:0], 3'b000} +: 8];
	assign ebyte  = (e_q < GA_W'(hb)) ? hsel : grd;

	assign ofree  = !out_valid || out_ready;
	assign pk_ins = pk_q | (64'(ebyte) << {pkc_q[2:0], 3'b000});
	assign adv    = cmd.row_acc || (cmd.accept && !sts.tail_now);

	always_comb begin
		gwe = cmd.rec_lo || cmd.rec_hi || cmd.pad_wr || cmd.row_fl ||
		      (cmd.row_acc && nsum >= 4'd8);
		gwd = 8'd0;
		if (cmd.rec_lo) gwd = {(run_q > RUN_W'(8'h7f)), run_q[6:0]};
		else if (cmd.rec_hi) gwd = run_q[14:7];
		else if (cmd.row_acc) gwd = acc_new[7:0];
		else if (cmd.row_fl) gwd = acc_q[7:0];
	end

	always_comb begin
		sts.tail_now  = tail_q || (start && (len_q < LEN_W'(MIN_CODED_LEN) ||
		                pos_q >= len_q || (len_q - pos_q) < LEN_W'(gs)));
		sts.block_end = (bf_q == bf_last);
		sts.rowzero   = rowzero;
		sts.run_full  = (run_q == RUN_W'(MAX_RUN));
		sts.run_nz    = (run_q != '0);
		sts.run_big   = (run_q > RUN_W'(8'h7f));
		sts.left_gt   = (left > LEN_W'(gs));
		sts.slot      = slot_q;
		sts.row_end   = (d_q == nd_m1);
		sts.rem_nz    = (nsum >= 4'd8) ? (nsum != 4'd8) : (nsum != 4'd0);
		sts.blk_last  = (bf_q == bf_last);
		sts.bf_zero   = (bf_q == '0);
		sts.push_ok   = (pkc_q != 4'd8) || ofree;
		sts.flush_ok  = (pkc_q == 4'd0) || ofree;
		sts.emit_last = ((e_q + GA_W'(1)) == total);
	end

	dzbr_ram #(.W(8), .D(BLK_DEPTH)) u_blk (
		.clk   (clk),
		.we    (cmd.accept && !sts.tail_now),
		.waddr (bf_q),
		.wdata (zz),
		.raddr (bf_q),
		.rdata (brd)
	);

	dzbr_ram #(.W(8), .D(GRP_DEPTH)) u_grp (
		.clk   (clk),
		.we    (gwe),
		.waddr (gf_q),
		.wdata (gwd),
		.raddr (graddr),
		.rdata (grd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q     <= 4'd1;
			len_q      <= '0;
			pos_q      <= '0;
			tail_q     <= 1'b0;
			bf_q       <= '0;
			d_q        <= '0;
			run_q      <= '0;
			slot_q     <= 1'b0;
			header_q   <= '0;
			gf_q       <= '0;
			e_q        <= '0;
			acc_q      <= '0;
			nacc_q     <= '0;
			pk_q       <= '0;
			pkc_q      <= '0;
			out_valid  <= 1'b0;
			out_bytes  <= '0;
			byte_count <= '0;
			burst_end  <= 1'b0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				prev_q[i] <= '0;
				orv_q[i]  <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index) len_q <= cfg_data;
			else dims_q <= cfg_data[DIMS_W-1:0];
			pos_q    <= '0;
			tail_q   <= 1'b0;
			bf_q     <= '0;
			d_q      <= '0;
			run_q    <= '0;
			slot_q   <= 1'b0;
			header_q <= '0;
			gf_q     <= '0;
			e_q      <= '0;
			acc_q    <= '0;
			nacc_q   <= '0;
			pk_q     <= '0;
			pkc_q    <= '0;
			for (int i = 0; i < MAX_DIMS; i++) begin
				prev_q[i] <= '0;
				orv_q[i]  <= '0;
			end
		end else begin
			if (out_valid && out_ready && !(cmd.emit_push && pkc_q == 4'd8) &&
			    !(cmd.flush && pkc_q != 4'd0))
				out_valid <= 1'b0;

			if (cmd.accept) begin
				if (pos_q != '1) pos_q <= pos_q + LEN_W'(1);
				if (sts.tail_now) begin
					tail_q <= 1'b1;
					pk_q   <= 64'(sample);
					pkc_q  <= 4'd1;
				end else begin
					prev_q[d_q] <= sample;
					for (int i = 0; i < MAX_DIMS; i++) begin
						orv_q[i] <= ((bf_q == '0) ? 8'd0 : orv_q[i]) |
						            ((3'(i) == d_q) ? zz : 8'd0);
					end
				end
			end

			if (adv) begin
				bf_q <= (bf_q == bf_last) ? '0 : bf_q + BA_W'(1);
				d_q  <= (d_q == nd_m1) ? '0 : d_q + 3'd1;
			end

			if (cmd.run_inc) run_q <= run_q + RUN_W'(1);
			if (cmd.rec_done) run_q <= '0;
			if (cmd.rec_done || cmd.slot_inc) slot_q <= ~slot_q;
			if (gwe) gf_q <= gf_q + GA_W'(1);

			if (cmd.hdr_wr) begin
				header_q <= header_q | (HDR_BITS'(codes) << (slot_q ? sh3 : 5'd0));
				acc_q    <= '0;
				nacc_q   <= '0;
			end

			if (cmd.row_acc) begin
				if (nsum >= 4'd8) begin
					acc_q  <= acc_new >> 8;
					nacc_q <= 3'(nsum - 4'd8);
				end else begin
					acc_q  <= acc_new;
					nacc_q <= 3'(nsum);
				end
			end
			if (cmd.row_fl) begin
				acc_q  <= '0;
				nacc_q <= '0;
			end

			if (cmd.emit_push) begin
				e_q <= cmd.emit_done ? '0 : e_q + GA_W'(1);
				if (pkc_q == 4'd8) begin
					out_valid  <= 1'b1;
					out_bytes  <= pk_q;
					byte_count <= 4'd8;
					burst_end  <= 1'b0;
					pk_q       <= 64'(ebyte);
					pkc_q      <= 4'd1;
				end else begin
					pk_q  <= pk_ins;
					pkc_q <= pkc_q + 4'd1;
				end
			end
			if (cmd.emit_done) begin
				header_q <= '0;
				gf_q     <= '0;
				slot_q   <= 1'b0;
			end
			if (cmd.set_tail) tail_q <= 1'b1;

			if (cmd.flush && pkc_q != 4'd0) begin
				out_valid  <= 1'b1;
				out_bytes  <= pk_q;
				byte_count <= pkc_q;
				burst_end  <= 1'b1;
				pk_q       <= '0;
				pkc_q      <= '0;
			end
		end
	end

endmodule

### rtl/delta_zigzag_bitpack_rle_encoder.sv
// ----------------------------------------------------------------------------
// delta_zigzag_bitpack_rle_encoder
// Delta/zigzag bit-packing encoder with zero-block run-length records;
// groups of two block slots behind a packed width header, raw tail.
//
// channel   dir  fields
// s_*       in   tdata[7:0] = sample
// m_*       out  tdata[63:0] = out_bytes, tdata[67:64] = byte_count,
//                tlast = burst_end
// cfg_*     in   cfg_index 0 = dims, 1 = stream_length
//
// A sample inside a block is written to the block RAM. The last sample of
// a block runs the sequencer: a decision state, a header state, a read and
// an accumulate state per stored code for the row walk through the block RAM
// plus a flush state per row with leftover bits, a read and a push state per
// emitted group byte, one per run record or pad byte, and a final flush state.
// No clearing pass after reset. Output stalls hold the sequencer when the
// byte packer is full or when the final flush finds the output register busy.
// ----------------------------------------------------------------------------
module delta_zigzag_bitpack_rle_encoder (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [dzbr_pkg::S_DATA_W-1:0]     s_tdata,   // [7:0] sample
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [dzbr_pkg::M_DATA_W-1:0]     m_tdata,   // [63:0] out_bytes, [67:64] byte_count
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [dzbr_pkg::LEN_W-1:0]        cfg_data
);
	import dzbr_pkg::*;

	cmd_t             cmd;
	sts_t             sts;
	logic [OUT_W-1:0] out_bytes;
	logic [CNT_W-1:0] byte_count;

	dzbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dzbr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.sample     (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_bytes  (out_bytes),
		.byte_count (byte_count),
		.burst_end  (m_tlast)
	);

	assign m_tdata = {4'd0, byte_count, out_bytes};

endmodule

### tb/tb_delta_zigzag_bitpack_rle_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_zigzag_bitpack_rle_encoder
// Self-checking bench for the delta/zigzag bit-pack encoder. A software copy
// of the encoder predicts the output beats of every accepted sample; beats
// are checked in order. Covers raw streams, coded groups, zero-block runs
// at stream end, dim clamping and random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_delta_zigzag_bitpack_rle_encoder;
	import dzbr_pkg::*;

	localparam logic REG_DIMS = 1'b0;
	localparam logic REG_LEN  = 1'b1;

	typedef struct {
		logic [63:0] bytes;
		logic [3:0]  cnt;
		logic        last;
	} beat_t;

	class encoder_scoreboard;
		logic [3:0]  dims_reg;
		logic [31:0] len_reg;
		logic [7:0]  last_val[MAX_DIMS];
		logic [7:0]  blk[BLK_DEPTH];
		int          blk_fill;
		logic [7:0]  grp[$];
		logic [47:0] hdr;
		int          run_len;
		int          slot;
		logic [31:0] pos;
		logic [3:0]  wid[MAX_DIMS];
		logic        tail;
		logic [7:0]  step[$];
		beat_t       pending[$];
		int          errors;

		function new();
			dims_reg = 4'd1;
			len_reg  = '0;
			errors   = 0;
			restart();
		endfunction

		function void restart();
			foreach (last_val[i]) last_val[i] = '0;
			foreach (wid[i]) wid[i] = '0;
			blk_fill = 0;
			grp.delete();
			hdr = '0;
			run_len = 0;
			slot = 0;
			pos = '0;
			tail = 1'b0;
		endfunction

		function void set_reg(logic idx, logic [31:0] val);
			if (idx == REG_DIMS) dims_reg = val[3:0];
			else len_reg = val;
			restart();
		endfunction

		function int nd();
			if (dims_reg == 0) return 1;
			if (dims_reg > MAX_DIMS) return MAX_DIMS;
			return dims_reg;
		endfunction

		function void emit_group();
			int hb;
			hb = (3 * nd() * GROUP_BLOCKS + 7) / 8;
			for (int i = 0; i < hb; i++) step.push_back(hdr[8*i +: 8]);
			foreach (grp[i]) step.push_back(grp[i]);
			grp.delete();
			hdr = '0;
			slot = 0;
		endfunction

		function void put_run_record();
			if (run_len > 'h7f) begin
				grp.push_back(8'(run_len & 'h7f) | 8'h80);
				grp.push_back(8'(run_len >> 7));
			end else begin
				grp.push_back(8'(run_len));
			end
			run_len = 0;
			slot++;
		endfunction

		function void write_header();
			int base;
			logic [2:0] code;
			base = 3 * nd() * slot;
			if (slot >= GROUP_BLOCKS) return;
			for (int d = 0; d < nd(); d++) begin
				code = (wid[d] == 8) ? 3'd7 : wid[d][2:0];
				for (int k = 0; k < 3; k++)
					if (code[k]) hdr[base + 3*d + k] = 1'b1;
			end
		endfunction

		function void write_rows();
			logic [31:0] acc;
			int nacc;
			for (int r = 0; r < BLOCK_ROWS; r++) begin
				acc = 0;
				nacc = 0;
				for (int d = 0; d < nd(); d++) begin
					acc |= 32'(blk[r*nd() + d]) << nacc;
					nacc += wid[d];
					while (nacc >= 8) begin
						grp.push_back(acc[7:0]);
						acc >>= 8;
						nacc -= 8;
					end
				end
				if (nacc > 0) grp.push_back(acc[7:0]);
			end
		endfunction

		function int zigzag_widths();
			int total, w;
			logic [7:0] p, v, dv, zz, orv;
			total = 0;
			for (int d = 0; d < nd(); d++) begin
				p = last_val[d];
				orv = 0;
				for (int r = 0; r < BLOCK_ROWS; r++) begin
					v = blk[r*nd() + d];
					dv = v - p;
					zz = {dv[6:0], 1'b0} ^ {8{dv[7]}};
					blk[r*nd() + d] = zz;
					orv |= zz;
					p = v;
				end
				last_val[d] = p;
				w = 0;
				while (w < 8 && (orv >> w) != 0) w++;
				if (w == 7) w = 8;
				wid[d] = 4'(w);
				total += w;
			end
			return total;
		endfunction

		function void code_block();
			int rowbits;
			longint left, gs;
			rowbits = zigzag_widths();
			gs = GROUP_BLOCKS * BLOCK_ROWS * nd();
			forever begin
				if (rowbits == 0 && run_len < MAX_RUN) begin
					run_len++;
					left = (len_reg > pos) ? longint'(len_reg - pos) : 0;
					if (left > gs) return;
					put_run_record();
					while (slot < GROUP_BLOCKS) begin
						grp.push_back(8'h00);
						slot++;
					end
					emit_group();
					tail = 1'b1;
					return;
				end
				if (run_len > 0) begin
					put_run_record();
					if (slot >= GROUP_BLOCKS) begin
						emit_group();
						continue;
					end
					if (rowbits == 0) continue;
				end
				write_header();
				write_rows();
				slot++;
				if (slot >= GROUP_BLOCKS) emit_group();
				return;
			end
		endfunction

		function void note_sample(logic [7:0] v);
			int n, cnt;
			beat_t b;
			step.delete();
			if (!tail && slot == 0 && run_len == 0 && blk_fill == 0) begin
				if (len_reg < MIN_CODED_LEN || pos >= len_reg ||
				    len_reg - pos < GROUP_BLOCKS * BLOCK_ROWS * nd())
					tail = 1'b1;
			end
			if (pos != 32'hffff_ffff) pos++;
			if (tail) begin
				step.push_back(v);
			end else begin
				blk[blk_fill++] = v;
				if (blk_fill >= BLOCK_ROWS * nd()) begin
					blk_fill = 0;
					code_block();
				end
			end
			n = (step.size() + 7) / 8;
			for (int k = 0; k < n; k++) begin
				cnt = step.size() - 8*k;
				if (cnt > 8) cnt = 8;
				b.bytes = '0;
				for (int j = 0; j < cnt; j++) b.bytes[8*j +: 8] = step[8*k + j];
				b.cnt = 4'(cnt);
				b.last = (k + 1 == n);
				pending.push_back(b);
			end
		endfunction

		function void check_beat(logic [M_DATA_W-1:0] data, logic last);
			beat_t e;
			if (pending.size() == 0) begin
				$error("unexpected beat: out_bytes %h", data[63:0]);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (data[63:0] !== e.bytes) begin
				$error("out_bytes: expected %h, actual %h", e.bytes, data[63:0]);
				errors++;
			end
			if (data[67:64] !== e.cnt) begin
				$error("byte_count: expected %0d, actual %0d", e.cnt, data[67:64]);
				errors++;
			end
			if (last !== e.last) begin
				$error("burst_end: expected %0d, actual %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;   // [7:0] sample
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;   // [63:0] out_bytes, [67:64] byte_count
	logic                m_tlast;
	logic                cfg_we;
	logic                cfg_index;
	logic [LEN_W-1:0]    cfg_data;

	encoder_scoreboard sb;
	bit                no_idle;
	int                stall_left;
	logic [7:0]        walk[MAX_DIMS];
	int                walk_bits[MAX_DIMS];

	delta_zigzag_bitpack_rle_encoder uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("delta_zigzag_bitpack_rle_encoder regression: fail");
		$finish;
	end

	function automatic int idle_len();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tlast);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				stall_left = idle_len();
				m_tready <= (stall_left == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(logic [7:0] v);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(v);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// Pick per-dim delta sizes at each block start; zero size repeats the value.
	task automatic send_stream(int count, int zero_pct);
		int nd, p, d, k;
		nd = sb.nd();
		for (p = 0; p < count; p++) begin
			d = p % nd;
			if (p % (BLOCK_ROWS * nd) == 0) begin
				for (int i = 0; i < nd; i++)
					walk_bits[i] = ($urandom_range(0, 99) < zero_pct) ? 0 :
						$urandom_range(0, 8);
				if ($urandom_range(0, 99) < zero_pct)
					for (int i = 0; i < nd; i++) walk_bits[i] = 0;
			end
			k = walk_bits[d];
			if (k == 8) walk[d] = 8'($urandom);
			else if (k > 0)
				walk[d] = walk[d] + 8'($urandom_range(0, (1 << k) - 1) - (1 << (k - 1)));
			send_sample(walk[d]);
			if (sb.pending.size() != 0 && $urandom_range(0, 199) == 0) drain();
		end
	endtask

	initial begin
		logic [7:0] raw_vals [8];
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIMS;
		cfg_data = '0;
		no_idle = 1'b0;
		stall_left = 0;
		raw_vals = '{8'h00, 8'hff, 8'h01, 8'h80, 8'h7f, 8'haa, 8'h55, 8'hfe};
		foreach (walk[i]) walk[i] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// raw pass-through with field extremes
		foreach (raw_vals[i]) send_sample(raw_vals[i]);

		write_reg(REG_DIMS, 32'd0);
		write_reg(REG_LEN, 32'd130);
		send_stream(132, 40);

		no_idle = 1'b1;
		write_reg(REG_DIMS, 32'd15);
		write_reg(REG_LEN, 32'd60);
		send_stream(60, 20);
		no_idle = 1'b0;

		s_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (sb.errors == 0)
			$display("delta_zigzag_bitpack_rle_encoder regression: pass");
		else
			$display("delta_zigzag_bitpack_rle_encoder regression: fail");
		$finish;
	end

endmodule
